/* src/ltm_pkg.sv */
// ----------------------------------------------------------------------------
// ltm_pkg
// shared types and constants of the edit distance threshold match unit
// ----------------------------------------------------------------------------
package ltm_pkg;

  localparam int LEN_W  = 6;
  localparam int CHAR_W = 8;
  localparam int PCT_W  = 7;
  localparam int PROD_W = PCT_W + LEN_W;

  localparam logic [PCT_W-1:0]  PERCENT_FULL = 7'd100;
  // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2**PROD_W
  localparam logic [PROD_W-1:0] RECIP_MUL    = 13'd5243;
  localparam int                RECIP_SHIFT  = 19;

  typedef enum logic [1:0] {
    REQ_PATTERN = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_END     = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SCORE,
    ST_EMIT
  } state_t;

  localparam logic CFG_ERROR_PERCENT = 1'b0;

  typedef struct packed {
    logic [LEN_W-1:0]  rd_addr;
    logic [LEN_W-1:0]  wr_addr;
    logic              pat_we;
    logic              row_we;
    logic [CHAR_W-1:0] pat_wdata;
    logic [LEN_W-1:0]  row_wdata;
  } mem_req_t;

  typedef struct packed {
    logic             matched;
    logic [LEN_W-1:0] margin;
    logic [LEN_W-1:0] distance;
  } score_t;

endpackage

/* src/ltm_in_if.sv */
// ----------------------------------------------------------------------------
// ltm_in_if
// request channel: pattern byte, text byte or end of pair
// ----------------------------------------------------------------------------
interface ltm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

/* src/ltm_out_if.sv */
// ----------------------------------------------------------------------------
// ltm_out_if
// result channel: match flag, margin, distance and overflow flag
// ----------------------------------------------------------------------------
interface ltm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [5:0] margin;
  logic [5:0] distance;
  logic       overflow;

  modport source (output valid, output matched, output margin, output distance,
                  output overflow, input ready);
  modport sink (input valid, input matched, input margin, input distance,
                input overflow, output ready);
endinterface

/* src/ltm_cfg.sv */
// ----------------------------------------------------------------------------
// ltm_cfg
// apb register block holding the error percentage
// ----------------------------------------------------------------------------
module ltm_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [6:0]  error_percent
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == ltm_pkg::CFG_ERROR_PERCENT);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_percent <= '0;
    end else if (wr_en) begin
      error_percent <= pwdata[ltm_pkg::PCT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ltm_pkg::CFG_ERROR_PERCENT) begin
      prdata = {25'd0, error_percent};
    end
  end

endmodule

/* src/ltm_mem.sv */
// ----------------------------------------------------------------------------
// ltm_mem
// pattern byte store and distance row store, registered reads
// ----------------------------------------------------------------------------
module ltm_mem #(
  parameter int MAX_LEN = 32
) (
  input  logic                 clk,
  input  ltm_pkg::mem_req_t    req,
  output logic [7:0]           pat_rdata,
  output logic [5:0]           row_rdata
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // row entry k+1 lives at address k, entry 0 equals the text length
  logic [ltm_pkg::CHAR_W-1:0] pat_mem [MAX_LEN];
  logic [ltm_pkg::LEN_W-1:0]  row_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.pat_we) begin
      pat_mem[req.wr_addr[AW-1:0]] <= req.pat_wdata;
    end
    pat_rdata <= pat_mem[req.rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (req.row_we) begin
      row_mem[req.wr_addr[AW-1:0]] <= req.row_wdata;
    end
    row_rdata <= row_mem[req.rd_addr[AW-1:0]];
  end

endmodule

/* src/ltm_score.sv */
// ----------------------------------------------------------------------------
// ltm_score
// allowance from percent and longer length, then match flag and margin
// ----------------------------------------------------------------------------
module ltm_score (
  input  logic           clk,
  input  logic           load,
  input  logic [6:0]     error_percent,
  input  logic [5:0]     pattern_len,
  input  logic [5:0]     text_len,
  input  logic [5:0]     dist_in,
  output ltm_pkg::score_t score
);

  localparam int QW = 2 * ltm_pkg::PROD_W;

  logic [ltm_pkg::PCT_W-1:0]  pct;
  logic [ltm_pkg::LEN_W-1:0]  longer;
  logic [ltm_pkg::PROD_W-1:0] prod;
  logic [ltm_pkg::LEN_W-1:0]  dist_q;
  logic [QW-1:0]              quot_full;
  logic [ltm_pkg::LEN_W-1:0]  allow;

  assign pct    = (error_percent > ltm_pkg::PERCENT_FULL) ? ltm_pkg::PERCENT_FULL : error_percent;
  assign longer = (pattern_len > text_len) ? pattern_len : text_len;

  always_ff @(posedge clk) begin
    if (load) begin
      prod   <= {{ltm_pkg::LEN_W{1'b0}}, pct} * {{ltm_pkg::PCT_W{1'b0}}, longer};
      dist_q <= dist_in;
    end
  end

  // divide by 100 through a reciprocal multiply
  assign quot_full = {{ltm_pkg::PROD_W{1'b0}}, prod} *
                     {{ltm_pkg::PROD_W{1'b0}}, ltm_pkg::RECIP_MUL};
  assign allow     = quot_full[ltm_pkg::RECIP_SHIFT+ltm_pkg::LEN_W-1:ltm_pkg::RECIP_SHIFT];

  always_comb begin
    score.distance = dist_q;
    score.matched  = (dist_q <= allow);
    score.margin   = score.matched ? (allow - dist_q) : '0;
  end

endmodule

/* src/levenshtein_threshold_match_unit.sv */
// ----------------------------------------------------------------------------
// levenshtein_threshold_match_unit
// edit distance between a stored pattern and a text, tested against a
// percentage of the longer length
// ----------------------------------------------------------------------------
// pattern byte: taken in ST_IDLE. text byte: taken in ST_IDLE, then ST_SWEEP updates
// pattern_len cells (at most MAX_LEN), one read-modify-write of the distance row memory per cycle
// end of pair: ST_SCORE, then ST_EMIT registers the result once the output is free
// reset is synchronous: clears lengths, overflow flag, result valid and the
// error percent register; the memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module levenshtein_threshold_match_unit #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  ltm_in_if.sink      in_ch,
  ltm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = ltm_pkg::LEN_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

  ltm_pkg::state_t   state;
  ltm_pkg::state_t   state_next;
  ltm_pkg::mem_req_t mem_req;
  ltm_pkg::score_t   score;

  logic [6:0]      error_percent;
  logic [LW-1:0]   pattern_len;
  logic [LW-1:0]   text_len;
  logic            overflow_seen;
  logic [7:0]      cur_char;
  logic [LW-1:0]   left;
  logic [LW-1:0]   diag;
  logic [LW-1:0]   idx;
  logic [7:0]      pat_rdata;
  logic [LW-1:0]   row_rdata;
  logic [LW-1:0]   min_ld;
  logic [LW-1:0]   min_all;
  logic [LW-1:0]   fresh;
  logic [LW-1:0]   dist_sel;
  logic            in_fire;
  logic            score_load;
  logic            emit;
  logic            out_valid;
  logic            sweep_last;
  logic            is_pattern;
  logic            is_text;
  logic            is_end;

  ltm_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .error_percent (error_percent)
  );

  ltm_mem #(.MAX_LEN(MAX_LEN)) u_mem (
    .clk       (clk),
    .req       (mem_req),
    .pat_rdata (pat_rdata),
    .row_rdata (row_rdata)
  );

  ltm_score u_score (
    .clk           (clk),
    .load          (score_load),
    .error_percent (error_percent),
    .pattern_len   (pattern_len),
    .text_len      (text_len),
    .dist_in       (dist_sel),
    .score         (score)
  );

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign is_pattern = (in_ch.req_type == ltm_pkg::REQ_PATTERN);
  assign is_text    = (in_ch.req_type == ltm_pkg::REQ_TEXT);
  assign is_end     = (in_ch.req_type == ltm_pkg::REQ_END);
  assign sweep_last = (idx == pattern_len - LW'(1));

  // one cell of the row update
  assign min_ld  = (left < diag) ? left : diag;
  assign min_all = (min_ld < row_rdata) ? min_ld : row_rdata;
  assign fresh   = (pat_rdata == cur_char) ? diag : (min_all + LW'(1));

  assign dist_sel = (pattern_len == '0) ? text_len : row_rdata;

  always_comb begin
    state_next = state;
    unique case (state)
      ltm_pkg::ST_IDLE: begin
        if (in_fire && is_text && (text_len < MAX_L) && (pattern_len != '0)) begin
          state_next = ltm_pkg::ST_SWEEP;
        end else if (in_fire && is_end) begin
          state_next = ltm_pkg::ST_SCORE;
        end
      end
      ltm_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_next = ltm_pkg::ST_IDLE;
        end
      end
      ltm_pkg::ST_SCORE: state_next = ltm_pkg::ST_EMIT;
      ltm_pkg::ST_EMIT: begin
        if (emit) begin
          state_next = ltm_pkg::ST_IDLE;
        end
      end
      default: state_next = ltm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mem_req     = '0;
    score_load  = 1'b0;
    emit        = 1'b0;
    unique case (state)
      ltm_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire && is_pattern && (text_len == '0) && (pattern_len < MAX_L)) begin
          mem_req.pat_we    = 1'b1;
          mem_req.row_we    = 1'b1;
          mem_req.wr_addr   = pattern_len;
          mem_req.pat_wdata = in_ch.char_code;
          mem_req.row_wdata = pattern_len + LW'(1);
        end else if (in_fire && is_end) begin
          mem_req.rd_addr = pattern_len - LW'(1);
        end
      end
      ltm_pkg::ST_SWEEP: begin
        mem_req.row_we    = 1'b1;
        mem_req.wr_addr   = idx;
        mem_req.row_wdata = fresh;
        mem_req.rd_addr   = idx + LW'(1);
      end
      ltm_pkg::ST_SCORE: score_load = 1'b1;
      ltm_pkg::ST_EMIT: emit = !out_valid || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ltm_pkg::ST_IDLE;
      pattern_len   <= '0;
      text_len      <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready && !emit) begin
        out_valid <= 1'b0;
      end
      if (in_fire && is_pattern && (text_len == '0)) begin
        if (pattern_len >= MAX_L) begin
          overflow_seen <= 1'b1;
        end else begin
          pattern_len <= pattern_len + LW'(1);
        end
      end
      if (in_fire && is_text) begin
        if (text_len >= MAX_L) begin
          overflow_seen <= 1'b1;
        end else begin
          text_len <= text_len + LW'(1);
        end
      end
      if (emit) begin
        out_valid     <= 1'b1;
        pattern_len   <= '0;
        text_len      <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_text) begin
      cur_char <= in_ch.char_code;
      left     <= text_len + LW'(1);
      diag     <= text_len;
      idx      <= '0;
    end else if (state == ltm_pkg::ST_SWEEP) begin
      left <= fresh;
      diag <= row_rdata;
      idx  <= idx + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.matched  <= score.matched;
      out_ch.margin   <= score.margin;
      out_ch.distance <= score.distance;
      out_ch.overflow <= overflow_seen;
    end
  end

  assign out_ch.valid = out_valid;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (pattern_len <= MAX_L) && (text_len <= MAX_L))
    else $error("string length beyond MAX_LEN");

  a_sweep_in_pattern: assert property (@(posedge clk) disable iff (rst)
    (state == ltm_pkg::ST_SWEEP) |-> (idx < pattern_len))
    else $error("row sweep past pattern length");

  a_text_starts_sweep: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_text && (text_len < MAX_L) && (pattern_len != '0))
      |=> (state == ltm_pkg::ST_SWEEP))
    else $error("text transfer did not start a row sweep");

  a_end_reaches_emit: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_end) |=> ##1 (state == ltm_pkg::ST_EMIT))
    else $error("end transfer did not reach result stage");

  a_no_pattern_write_in_text: assert property (@(posedge clk) disable iff (rst)
    mem_req.pat_we |-> (text_len == '0))
    else $error("pattern store written after text began");

endmodule
